>>> hw/rtl/htfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfcc_pkg
// shared widths, constants and the crc-8 helper for the sensor frame checker
// ----------------------------------------------------------------------------
package htfcc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned RawWidth   = 16;
   localparam int unsigned ValueWidth = 15;
   localparam int unsigned ScaleWidth = 15;
   localparam int unsigned ProdWidth  = RawWidth + ScaleWidth;

   // crc-8, x^8 + x^5 + x^4 + 1, msb first
   localparam logic [ByteWidth-1:0] CrcPoly = 8'h31;

   // two status bits at the bottom of the data word
   localparam logic [RawWidth-1:0] StatusMask = 16'hFFFC;

   // hundredths: offset + floor(scale * v / 2^16)
   localparam logic [ScaleWidth-1:0] HumScale   = 15'd12500;
   localparam logic [ScaleWidth-1:0] TempScale  = 15'd17572;
   localparam logic signed [ValueWidth:0] HumOffset  = -16'sd600;
   localparam logic signed [ValueWidth:0] TempOffset = -16'sd4685;

   // measurement kind codes
   localparam logic KindHumidity    = 1'b0;
   localparam logic KindTemperature = 1'b1;

   // position of a word within a frame
   typedef enum logic [1:0] {
      POS_MSB = 2'd0,
      POS_LSB = 2'd1,
      POS_CRC = 2'd2
   } pos_type;

   // fold one byte into the running crc
   function automatic logic [ByteWidth-1:0] crc8_feed(
      input logic [ByteWidth-1:0] crc,
      input logic [ByteWidth-1:0] data
   );
      logic [ByteWidth-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < ByteWidth; i++) begin
         if (c[ByteWidth-1]) begin
            c = {c[ByteWidth-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[ByteWidth-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/humidity_temp_frame_check_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert
// crc check and fixed-point conversion of a three-word sensor reply
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per transfer (rx_byte) in the order data msb, data
//   lsb, crc. frame_start marks the first word of a frame and restarts the
//   word counter; kind (0 humidity, 1 temperature) is sampled with that word.
//   without frame_start the counter runs msb, lsb, crc and wraps.
//   rsp channel: one result per crc word with the raw 16-bit word, the
//   reading in hundredths (signed), the frame kind and a crc mismatch flag.
//   the msb and lsb words give no result.
// timing
//   a crc word taken into the input register is checked against the running
//   crc and converted from the stored data bytes, and its result is written
//   to the result register, which drives rsp_valid. one word per cycle is
//   taken in steady state while no held result blocks a crc word; the
//   conversion is one 16x15 constant multiply plus an offset add feeding the result register.
// reset
//   synchronous, clears both valid flags, the counter and the crc state.
// backpressure
//   while rsp_stall holds a result, the result register keeps its contents;
//   a crc word waiting behind it then raises req_stall, while msb and lsb
//   words keep flowing since they produce no result.
// ----------------------------------------------------------------------------
module humidity_temp_frame_check_convert (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   // request channel
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic [htfcc_pkg::ByteWidth-1:0]             req_rx_byte,
   input  wire logic                                        req_frame_start,
   input  wire logic                                        req_kind,
   // response channel
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic [htfcc_pkg::RawWidth-1:0]                   rsp_raw_value,
   output logic signed [htfcc_pkg::ValueWidth-1:0]          rsp_value_x100,
   output logic                                             rsp_result_kind,
   output logic                                             rsp_crc_error
);
   import htfcc_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_start_ff;
   logic                 in_kind_ff;

   // frame state
   pos_type              count_ff, count_in;
   logic [ByteWidth-1:0] crc_ff, crc_in;
   logic [ByteWidth-1:0] high_ff, high_in;
   logic [ByteWidth-1:0] low_ff, low_in;
   logic                 kind_ff, kind_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [RawWidth-1:0]   out_raw_ff;
   logic [ValueWidth-1:0] out_value_ff;
   logic                  out_kind_ff;
   logic                  out_err_ff;

   // datapath
   pos_type                      pos;
   logic                         produce;
   logic                         advance;
   logic                         accept;
   logic                         taken;
   logic [RawWidth-1:0]          raw_word;
   logic [RawWidth-1:0]          masked_word;
   logic [ScaleWidth-1:0]        scale;
   logic signed [ValueWidth:0]   offset;
   logic [ProdWidth-1:0]         product;
   logic signed [ValueWidth:0]   value_wide;

   // ---------------------------------------------------------------------
   // frame position: frame_start forces the msb slot
   // ---------------------------------------------------------------------
   always_comb begin
      pos = in_start_ff ? POS_MSB : count_ff;
   end

   // next frame state and whether this word closes a frame
   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      kind_in  = kind_ff;
      produce  = 1'b0;
      unique case (pos)
         POS_LSB: begin
            low_in   = in_byte_ff;
            crc_in   = crc8_feed(crc_ff, in_byte_ff);
            count_in = POS_CRC;
         end
         POS_CRC: begin
            produce  = 1'b1;
            count_in = POS_MSB;
         end
         default: begin
            // msb word, also covers the unused counter code
            high_in  = in_byte_ff;
            kind_in  = in_kind_ff;
            crc_in   = crc8_feed('0, in_byte_ff);
            count_in = POS_LSB;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // conversion: offset + floor(scale * (raw & mask) / 2^16)
   // ---------------------------------------------------------------------
   always_comb begin
      raw_word    = {high_ff, low_ff};
      masked_word = raw_word & StatusMask;
      scale       = (kind_ff == KindTemperature) ? TempScale : HumScale;
      offset      = (kind_ff == KindTemperature) ? TempOffset : HumOffset;
      product     = ProdWidth'(masked_word) * ProdWidth'(scale);
      value_wide  = $signed({1'b0, product[ProdWidth-1:RawWidth]}) + offset;
   end

   // ---------------------------------------------------------------------
   // handshake: the input word moves on unless its result has nowhere to go
   // ---------------------------------------------------------------------
   assign taken   = out_valid_ff && !rsp_stall;
   assign advance = in_valid_ff && (!produce || !out_valid_ff || !rsp_stall);
   assign accept  = req_valid && !req_stall;

   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance && produce) begin
         out_valid_in = 1'b1;
      end else if (taken) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= POS_MSB;
         crc_ff       <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         kind_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            count_ff <= count_in;
            crc_ff   <= crc_in;
            high_ff  <= high_in;
            low_ff   <= low_in;
            kind_ff  <= kind_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
         in_kind_ff  <= req_kind;
      end
      if (advance && produce) begin
         out_raw_ff   <= raw_word;
         out_value_ff <= value_wide[ValueWidth-1:0];
         out_kind_ff  <= kind_ff;
         out_err_ff   <= (crc_ff != in_byte_ff);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_raw_value   = out_raw_ff;
   assign rsp_value_x100  = $signed(out_value_ff);
   assign rsp_result_kind = out_kind_ff;
   assign rsp_crc_error   = out_err_ff;

endmodule
`default_nettype wire

>>> hw/rtl/htfcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfcc_checker
// port-level checks for the sensor frame checker, bound to the top level
// ----------------------------------------------------------------------------
module htfcc_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [htfcc_pkg::RawWidth-1:0]       rsp_raw_value,
   input wire logic signed [htfcc_pkg::ValueWidth-1:0] rsp_value_x100,
   input wire logic                                 rsp_result_kind
);
   import htfcc_pkg::*;

   // nothing comes out and nothing is held off in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result word valid or request stalled right after reset");

   // a held result keeps its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_raw_value)
         && $stable(rsp_value_x100) && $stable(rsp_result_kind))
      else $error("stalled result word changed");

   // humidity readings stay inside the conversion range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KindHumidity) |->
         (rsp_value_x100 >= -15'sd600) && (rsp_value_x100 <= 15'sd11899))
      else $error("humidity reading out of range");

   // temperature readings stay inside the conversion range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KindTemperature) |->
         (rsp_value_x100 >= -15'sd4685) && (rsp_value_x100 <= 15'sd12885))
      else $error("temperature reading out of range");

endmodule

bind humidity_temp_frame_check_convert htfcc_checker u_htfcc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_raw_value   (rsp_raw_value),
   .rsp_value_x100  (rsp_value_x100),
   .rsp_result_kind (rsp_result_kind)
);
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sensor frame crc check and converter
// ----------------------------------------------------------------------------
// a scoreboard class tracks the frame position, running crc and data bytes
// of every accepted word and queues the reading expected on each crc word.
// results are compared field by field in arrival order. stimulus starts
// with directed frames covering extremes, bad crc, back-to-back frames and
// restarts at every frame position, then runs mostly well-formed random
// frames mixed with bad crc, cut-off frames and noise words. both sides
// idle in random bursts; the receiver once holds off long enough to back
// the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

   import htfcc_pkg::*;

   // cycles without any transfer before the run is declared hung
   localparam int unsigned WatchdogLimit = 3000;
   // long receiver hold-off to back the block up
   localparam int unsigned HoldCycles    = 300;
   // extra cycles after the last expected reading
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned TotalWords    = 1720;
   localparam int unsigned TailWords     = 1500;
   localparam int unsigned HoldAtWord    = 600;

   typedef struct packed {
      logic [RawWidth-1:0]          raw;
      logic signed [ValueWidth-1:0] value;
      logic                         kind;
      logic                         crc_err;
   } frame_reading_type;

   // ------------------------------------------------------------------------
   // scoreboard: frame tracker plus queue of expected readings
   // ------------------------------------------------------------------------
   class frame_scoreboard;
      localparam logic [7:0]  CRC_POLY     = 8'h31;
      localparam logic [15:0] STATUS_CLEAR = 16'hFFFC;
      localparam logic [31:0] HUM_SCALE    = 32'd12500;
      localparam logic [31:0] TEMP_SCALE   = 32'd17572;
      localparam int          HUM_OFFSET   = -600;
      localparam int          TEMP_OFFSET  = -4685;

      pos_type           word_pos;
      logic [7:0]        crc_acc;
      logic [7:0]        data_msb;
      logic [7:0]        data_lsb;
      logic              frame_kind;
      frame_reading_type expected_readings[$];
      int unsigned       errors;

      function new();
         word_pos   = POS_MSB;
         crc_acc    = 8'h00;
         data_msb   = 8'h00;
         data_lsb   = 8'h00;
         frame_kind = 1'b0;
         errors     = 0;
      endfunction

      // msb-first crc-8, one data bit at a time
      static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
         logic [7:0] acc;
         logic       fb;
         acc = crc;
         for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         return acc;
      endfunction

      static function logic signed [ValueWidth-1:0] reading_x100(logic [15:0] raw,
                                                                 logic kind);
         logic [31:0] product;
         int          hundredths;
         if (kind == KindTemperature) begin
            product    = TEMP_SCALE * {16'h0000, raw & STATUS_CLEAR};
            hundredths = TEMP_OFFSET + int'(product >> 16);
         end else begin
            product    = HUM_SCALE * {16'h0000, raw & STATUS_CLEAR};
            hundredths = HUM_OFFSET + int'(product >> 16);
         end
         return hundredths[ValueWidth-1:0];
      endfunction

      function bit frame_aligned();
         return word_pos == POS_MSB;
      endfunction

      function void note_word(logic [7:0] b, logic start, logic kind);
         pos_type           pos;
         frame_reading_type r;
         if (start) begin
            pos = POS_MSB;
         end else begin
            pos = word_pos;
         end
         case (pos)
            POS_LSB: begin
               data_lsb = b;
               crc_acc  = crc8_step(crc_acc, b);
               word_pos = POS_CRC;
            end
            POS_CRC: begin
               r.raw     = {data_msb, data_lsb};
               r.value   = reading_x100(r.raw, frame_kind);
               r.kind    = frame_kind;
               r.crc_err = (crc_acc != b);
               expected_readings.push_back(r);
               word_pos  = POS_MSB;
            end
            default: begin
               data_msb   = b;
               frame_kind = kind;
               crc_acc    = crc8_step(8'h00, b);
               word_pos   = POS_LSB;
            end
         endcase
      endfunction

      function void check_result(logic [15:0] raw, logic signed [ValueWidth-1:0] value,
                                 logic kind, logic crc_err);
         frame_reading_type want;
         if (expected_readings.size() == 0) begin
            $display("%0t: reading expected none actual raw_value %h", $time, raw);
            errors++;
            return;
         end
         want = expected_readings.pop_front();
         if (want.raw !== raw) begin
            $display("%0t: raw_value expected %h actual %h", $time, want.raw, raw);
            errors++;
         end
         if (want.value !== value) begin
            $display("%0t: value_x100 expected %0d actual %0d", $time, want.value, value);
            errors++;
         end
         if (want.kind !== kind) begin
            $display("%0t: result_kind expected %b actual %b", $time, want.kind, kind);
            errors++;
         end
         if (want.crc_err !== crc_err) begin
            $display("%0t: crc_error expected %b actual %b", $time, want.crc_err, crc_err);
            errors++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, dut
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   always #10 clock = ~clock;

   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [ByteWidth-1:0]         req_rx_byte;
   logic                         req_frame_start;
   logic                         req_kind;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [RawWidth-1:0]          rsp_raw_value;
   logic signed [ValueWidth-1:0] rsp_value_x100;
   logic                         rsp_result_kind;
   logic                         rsp_crc_error;

   humidity_temp_frame_check_convert dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .req_kind        (req_kind),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_raw_value   (rsp_raw_value),
      .rsp_value_x100  (rsp_value_x100),
      .rsp_result_kind (rsp_result_kind),
      .rsp_crc_error   (rsp_crc_error)
   );

   frame_scoreboard readings = new();

   int unsigned words_sent = 0;
   int unsigned gap_pct    = 10;   // sender idle chance per word
   int unsigned stall_pct  = 10;   // receiver stall chance per cycle
   bit          tail       = 1'b0; // last stretch: no idling at all
   bit          hold_req   = 1'b0; // sender asks receiver for the long hold
   bit          hold_issued = 1'b0;
   int unsigned quiet_cycles = 0;

   // idle density changes now and then so quiet stretches show up too
   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 35;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // monitor: outputs sampled at the edge, before the dut updates them
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         readings.check_result(rsp_raw_value, rsp_value_x100, rsp_result_kind,
                               rsp_crc_error);
      end
   end

   // watchdog: any transfer on either channel counts as progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // sender tasks
   // ------------------------------------------------------------------------
   // offer one word and hold it until the dut takes it
   task automatic send_word(input logic [7:0] b, input logic start, input logic kind);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= start;
      req_kind        <= kind;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readings.note_word(b, start, kind);
      words_sent++;
      if (words_sent % 64 == 0) begin
         gap_pct = tail ? 0 : pick_idle_pct();
      end
   endtask

   // full frame; crc_flip != 0 corrupts the crc word
   task automatic send_frame(input logic [15:0] data, input logic kind,
                             input logic start, input logic [7:0] crc_flip);
      logic [7:0] crc;
      crc = frame_scoreboard::crc8_step(frame_scoreboard::crc8_step(8'h00, data[15:8]),
                                        data[7:0]) ^ crc_flip;
      send_word(data[15:8], start, kind);
      // kind is only sampled on the msb word, so the other words carry noise
      send_word(data[7:0], 1'b0, ~kind);
      send_word(crc, 1'b0, 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned choice;
      logic [15:0] data;
      logic        start;
      logic        kind;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rx_byte     <= '0;
      req_frame_start <= 1'b0;
      req_kind        <= 1'b0;
      rsp_stall       <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // receiver: random stall bursts plus the one long hold-off
      fork
         forever begin
            if (hold_req) begin
               rsp_stall <= 1'b1;
               repeat (HoldCycles) @(posedge clock);
               hold_req = 1'b0;
            end else if (!tail && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b0;
               @(posedge clock);
            end
            if ($urandom_range(0, 49) == 0) begin
               stall_pct = pick_idle_pct();
            end
         end
      join_none

      // directed: extremes of the word for both kinds, back-to-back frames
      send_frame(16'h0000, KindHumidity, 1'b1, 8'h00);
      send_frame(16'hFFFF, KindHumidity, 1'b0, 8'h00);
      send_frame(16'hFFFF, KindTemperature, 1'b1, 8'h00);
      // status bits only, then all data bits, both with a bad crc
      send_frame(16'h0003, KindTemperature, 1'b0, 8'h01);
      send_frame(16'hFFFC, KindHumidity, 1'b0, 8'h80);
      // frame start where the lsb word was due: partial frame dropped
      send_word(8'hA5, 1'b1, KindTemperature);
      send_frame(16'h5A3C, KindHumidity, 1'b1, 8'h00);
      // frame start where the crc word was due
      send_word(8'h12, 1'b1, KindHumidity);
      send_word(8'h34, 1'b0, KindHumidity);
      send_frame(16'h8001, KindTemperature, 1'b1, 8'h00);

      // random: mostly good frames, some bad crc, cut-off frames and noise
      while (words_sent < TotalWords) begin
         if (words_sent >= TailWords) begin
            tail    = 1'b1;
            gap_pct = 0;
         end
         if (!hold_issued && words_sent >= HoldAtWord) begin
            hold_issued = 1'b1;
            hold_req    = 1'b1;
         end
         choice = $urandom_range(0, 99);
         data   = 16'($urandom_range(0, 65535));
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0:       data = 16'h0000;
               1:       data = 16'hFFFF;
               2:       data = 16'h0003;
               default: data = 16'hFFFC;
            endcase
         end
         kind  = 1'($urandom_range(0, 1));
         // a frame that follows a broken one needs its start flag
         start = !readings.frame_aligned() || 1'($urandom_range(0, 1));
         if (choice < 70) begin
            send_frame(data, kind, start, 8'h00);
         end else if (choice < 80) begin
            send_frame(data, kind, start, 8'($urandom_range(1, 255)));
         end else if (choice < 90) begin
            send_word(data[15:8], start, kind);
            if ($urandom_range(0, 1) == 1) begin
               send_word(data[7:0], 1'b0, kind);
            end
         end else begin
            send_word(data[7:0], 1'($urandom_range(0, 1)), kind);
         end
      end

      // drain: every reading in, then wait out any strays
      req_valid <= 1'b0;
      while (readings.expected_readings.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (readings.errors == 0 && readings.expected_readings.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
